### hdl/wcsg_pkg.sv
`timescale 1ns / 1ps

package wcsg_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_WRITE  = 2'd1,
      REQ_PERIOD = 2'd2,
      REQ_LENGTH = 2'd3
   } req_kind_type;

   localparam int WAVE_DEPTH = 16;
   localparam int WAVE_AW    = $clog2(WAVE_DEPTH);

   typedef logic [WAVE_AW-1:0] wave_addr_type;
   typedef logic [7:0]         byte_type;

   // register map
   localparam logic [15:0] ADDR_DAC    = 16'hFF1A;
   localparam logic [15:0] ADDR_LENGTH = 16'hFF1B;
   localparam logic [15:0] ADDR_VOLUME = 16'hFF1C;
   localparam logic [15:0] ADDR_PLOW   = 16'hFF1D;
   localparam logic [15:0] ADDR_CTRL   = 16'hFF1E;
   localparam logic [11:0] ADDR_WAVE_PAGE = 12'hFF3;   // 0xFF30 - 0xFF3F

   // read-back masks: unused bits read as one
   localparam logic [7:0] MASK_DAC    = 8'h7F;
   localparam logic [7:0] MASK_VOLUME = 8'h9F;
   localparam logic [7:0] MASK_CTRL   = 8'hBF;
   localparam logic [7:0] OPEN_BUS    = 8'hFF;

   localparam logic [11:0] PERIOD_SPAN  = 12'd2048;
   localparam logic [8:0]  LENGTH_SPAN  = 9'd256;

endpackage

### hdl/wave_channel_sound_generator.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                  Contents
// req      in         req_tvalid/tready      tuser: request kind; tdata: address, write data
// rsp      out        rsp_tvalid/tready      tdata: read data, sample, channel on
//
// Three register stages: input register, state update (wave RAM read issued
// here), output register. One transaction per cycle sustained while rsp is not
// stalled; rsp_tvalid rises once a request reaches the output register. Reset
// is synchronous and clears all channel state and the wave RAM valid bits. A
// stalled rsp channel freezes the whole pipe, so req_tready drops with it.
module wave_channel_sound_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] req_type
   input  logic [23:0] req_tdata,    // [15:0] address, [23:16] write_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [7:0] read_data, [11:8] sample, [12] channel_on
);
   import wcsg_pkg::*;

   // ---------------------------------------------------------------------
   // pipe control: every stage moves together
   // ---------------------------------------------------------------------
   logic advance;
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: input register
   // ---------------------------------------------------------------------
   req_kind_type s1_kind_ff;
   logic [15:0]  s1_addr_ff;
   byte_type     s1_data_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= req_kind_type'(req_tuser);
         s1_addr_ff <= req_tdata[15:0];
         s1_data_ff <= req_tdata[23:16];
      end
   end

   // ---------------------------------------------------------------------
   // channel state; only the register bits that are read back or a trigger uses
   // are kept (length register reads all ones, so only its count is held)
   // ---------------------------------------------------------------------
   logic        dac_on_ff, dac_on_in;
   logic [1:0]  vol_code_ff, vol_code_in;
   logic        len_en_ff, len_en_in;
   byte_type    plow_ff, plow_in;
   logic        running_ff, running_in;
   logic [10:0] period_ff, period_in;
   logic [12:0] timer_ff, timer_in;
   logic [4:0]  pos_ff, pos_in;
   logic [8:0]  len_cnt_ff, len_cnt_in;

   logic        s1_fire;
   logic        wave_hit;
   logic        wave_we;
   logic [12:0] timer_dec;
   logic [10:0] trig_period;
   byte_type    rd_pre;

   assign s1_fire  = advance && s1_valid_ff;
   assign wave_hit = (s1_addr_ff[15:4] == ADDR_WAVE_PAGE);
   assign wave_we  = s1_valid_ff && (s1_kind_ff == REQ_WRITE) && wave_hit;
   assign timer_dec   = timer_ff - 13'd1;
   assign trig_period = {s1_data_ff[2:0], plow_ff};

   // twice (2048 - period); 2048 - period fits 12 bits, doubled fits 13
   function automatic logic [12:0] reload_of(input logic [10:0] per);
      logic [11:0] span;
      span = PERIOD_SPAN - {1'b0, per};
      return {span, 1'b0};
   endfunction

   always_comb begin
      dac_on_in   = dac_on_ff;
      vol_code_in = vol_code_ff;
      len_en_in   = len_en_ff;
      plow_in     = plow_ff;
      running_in  = running_ff;
      period_in   = period_ff;
      timer_in    = timer_ff;
      pos_in      = pos_ff;
      len_cnt_in  = len_cnt_ff;

      unique case (s1_kind_ff)
         REQ_READ: begin
         end
         REQ_WRITE: begin
            priority if (s1_addr_ff == ADDR_DAC) begin
               dac_on_in = s1_data_ff[7];
               if (!s1_data_ff[7]) running_in = 1'b0;
            end else if (s1_addr_ff == ADDR_LENGTH) begin
               len_cnt_in = LENGTH_SPAN - {1'b0, s1_data_ff};
            end else if (s1_addr_ff == ADDR_VOLUME) begin
               vol_code_in = s1_data_ff[6:5];
            end else if (s1_addr_ff == ADDR_PLOW) begin
               plow_in = s1_data_ff;
            end else if (s1_addr_ff == ADDR_CTRL) begin
               len_en_in = s1_data_ff[6];
               if (s1_data_ff[7]) begin
                  // trigger: arm if DAC is on, reload everything else anyway
                  if (dac_on_ff) running_in = 1'b1;
                  if (len_cnt_ff == '0) len_cnt_in = LENGTH_SPAN;
                  period_in = trig_period;
                  timer_in  = reload_of(trig_period);
                  pos_in    = '0;
               end
            end else begin
               // wave RAM or unmapped: no register change
            end
         end
         REQ_PERIOD: begin
            // idle timer stays idle until the next trigger
            if (timer_ff != '0) begin
               if (timer_dec == '0) begin
                  timer_in = reload_of(period_ff);
                  pos_in   = pos_ff + 5'd1;
               end else begin
                  timer_in = timer_dec;
               end
            end
         end
         REQ_LENGTH: begin
            if (len_en_ff && (len_cnt_ff != '0)) begin
               len_cnt_in = len_cnt_ff - 9'd1;
               if (len_cnt_ff == 9'd1) running_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // register read-back, wave RAM hits resolved one stage later
   always_comb begin
      rd_pre = OPEN_BUS;
      if (s1_kind_ff == REQ_READ) begin
         priority if (s1_addr_ff == ADDR_DAC) begin
            rd_pre = {dac_on_ff, 7'd0} | MASK_DAC;
         end else if (s1_addr_ff == ADDR_VOLUME) begin
            rd_pre = {1'b0, vol_code_ff, 5'd0} | MASK_VOLUME;
         end else if (s1_addr_ff == ADDR_CTRL) begin
            rd_pre = {1'b0, len_en_ff, 6'd0} | MASK_CTRL;
         end else begin
            rd_pre = OPEN_BUS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dac_on_ff   <= 1'b0;
         vol_code_ff <= '0;
         len_en_ff   <= 1'b0;
         plow_ff     <= '0;
         running_ff  <= 1'b0;
         period_ff   <= '0;
         timer_ff    <= '0;
         pos_ff      <= '0;
         len_cnt_ff  <= '0;
      end else if (s1_fire) begin
         dac_on_ff   <= dac_on_in;
         vol_code_ff <= vol_code_in;
         len_en_ff   <= len_en_in;
         plow_ff     <= plow_in;
         running_ff  <= running_in;
         period_ff   <= period_in;
         timer_ff    <= timer_in;
         pos_ff      <= pos_in;
         len_cnt_ff  <= len_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // wave RAM: port A serves bus reads, port B fetches the byte under the
   // updated play position (write-through covers a write to that byte)
   // ---------------------------------------------------------------------
   byte_type ram_rd_a, ram_rd_b;

   wcsg_wave_ram u_wave_ram (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .wr_en     (wave_we),
      .wr_addr   (s1_addr_ff[WAVE_AW-1:0]),
      .wr_data   (s1_data_ff),
      .rd_addr_a (s1_addr_ff[WAVE_AW-1:0]),
      .rd_data_a (ram_rd_a),
      .rd_addr_b (pos_in[4:1]),
      .rd_data_b (ram_rd_b)
   );

   // ---------------------------------------------------------------------
   // stage 2: what the result needs from the post-update state
   // ---------------------------------------------------------------------
   typedef struct packed {
      byte_type   rd_pre;
      logic       wave_read;   // bus read inside the wave RAM page
      logic       running;
      logic       audible;     // running with DAC on
      logic [1:0] vol_code;
      logic       pos_lsb;
   } stage2_type;

   stage2_type s2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff.rd_pre    <= rd_pre;
         s2_ff.wave_read <= (s1_kind_ff == REQ_READ) && wave_hit;
         s2_ff.running   <= running_in;
         s2_ff.audible   <= running_in && dac_on_in;
         s2_ff.vol_code  <= vol_code_in;
         s2_ff.pos_lsb   <= pos_in[0];
      end
   end

   byte_type   rd_final;
   logic [3:0] nibble;
   logic [3:0] sample;

   // wave RAM reads all ones while the channel plays
   assign rd_final = (s2_ff.wave_read && !s2_ff.running) ? ram_rd_a : s2_ff.rd_pre;
   // high nibble first
   assign nibble   = s2_ff.pos_lsb ? ram_rd_b[3:0] : ram_rd_b[7:4];

   always_comb begin
      sample = '0;
      if (s2_ff.audible) begin
         unique case (s2_ff.vol_code)
            2'd0:    sample = '0;
            2'd1:    sample = nibble;
            2'd2:    sample = nibble >> 1;
            2'd3:    sample = nibble >> 2;
            default: sample = '0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: output register
   // ---------------------------------------------------------------------
   logic [15:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {3'd0, s2_ff.running, sample, rd_final};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

### hdl/wcsg_wave_ram.sv
`timescale 1ns / 1ps

// 16 x 8 wave RAM, one write port, two registered read ports.
// Entries read as zero until first written. Port B is write-through.
module wcsg_wave_ram (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   wr_en,
   input  wcsg_pkg::wave_addr_type wr_addr,
   input  wcsg_pkg::byte_type     wr_data,
   input  wcsg_pkg::wave_addr_type rd_addr_a,
   output wcsg_pkg::byte_type     rd_data_a,
   input  wcsg_pkg::wave_addr_type rd_addr_b,
   output wcsg_pkg::byte_type     rd_data_b
);
   import wcsg_pkg::*;

   byte_type                mem [WAVE_DEPTH];
   logic [WAVE_DEPTH-1:0]   valid_ff;
   byte_type                rd_a_ff;
   byte_type                rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable && wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : '0;
         if (wr_en && (wr_addr == rd_addr_b)) begin
            rd_b_ff <= wr_data;
         end else begin
            rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sim/wave_channel_sound_generator_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the wave channel. Requests are queued by the stimulus
// process, presented by a clocked driver and predicted at acceptance; a clocked
// monitor checks every response transaction against the oldest prediction.
module wave_channel_sound_generator_tb;
   import wcsg_pkg::*;

   localparam int STALL_LIMIT  = 5000;   // cycles with no transaction on either side
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off, fills the pipe
   localparam int HOLD_AFTER   = 200;    // requests accepted before the hold-off starts
   localparam int PHASE_ITEMS  = 650;
   localparam int DRAIN_CYCLES = 10;     // three-stage pipe, plus margin

   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  addr;
      byte_type     wdata;
   } wave_req_type;

   typedef struct packed {
      byte_type   read_data;
      logic [3:0] sample;
      logic       channel_on;
   } wave_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;     // [1:0] req_type
   logic [23:0] req_tdata  = '0;     // [15:0] address, [23:16] write_data
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] read_data, [11:8] sample, [12] channel_on

   wave_channel_sound_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wave_req_type req_backlog[$];     // requests not yet presented
   wave_rsp_type rsp_expected[$];    // predicted responses, oldest first
   wave_req_type req_on_bus;         // request currently offered on req

   int   send_idle_pct = 30;
   int   rsp_idle_pct  = 47;
   logic hold_active   = 1'b0;
   int   req_accepted  = 0;
   int   items_queued  = 0;
   int   err_count     = 0;
   int   quiet_cycles  = 0;

   // predicted channel state
   byte_type    ch_dac, ch_vol, ch_plow, ch_ctrl;
   logic        ch_running;
   logic [10:0] ch_period;
   logic [12:0] ch_timer;
   logic [4:0]  ch_pos;
   logic [8:0]  ch_len_cnt;
   byte_type    ch_wave [WAVE_DEPTH];

   always #6 clock = ~clock;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // timer reload: twice the distance of the latched period from the span
   function automatic logic [12:0] reload_ticks();
      return {PERIOD_SPAN - {1'b0, ch_period}, 1'b0};
   endfunction

   // apply one request to the predicted state, return the response it yields
   function automatic wave_rsp_type predict_channel(wave_req_type r);
      wave_rsp_type res;
      byte_type     wave_byte;
      logic [3:0]   nib;
      res.read_data = OPEN_BUS;
      case (r.kind)
         REQ_READ: begin
            if (r.addr == ADDR_DAC) res.read_data = ch_dac | MASK_DAC;
            else if (r.addr == ADDR_VOLUME) res.read_data = ch_vol | MASK_VOLUME;
            else if (r.addr == ADDR_CTRL) res.read_data = ch_ctrl | MASK_CTRL;
            else if (r.addr[15:4] == ADDR_WAVE_PAGE && !ch_running)
               res.read_data = ch_wave[r.addr[3:0]];
         end
         REQ_WRITE: begin
            if (r.addr == ADDR_DAC) begin
               ch_dac = r.wdata;
               if (!r.wdata[7]) ch_running = 1'b0;
            end else if (r.addr == ADDR_LENGTH) begin
               ch_len_cnt = LENGTH_SPAN - {1'b0, r.wdata};
            end else if (r.addr == ADDR_VOLUME) begin
               ch_vol = r.wdata;
            end else if (r.addr == ADDR_PLOW) begin
               ch_plow = r.wdata;
            end else if (r.addr == ADDR_CTRL) begin
               ch_ctrl = r.wdata;
               if (r.wdata[7]) begin
                  // trigger: arms only with DAC on, but always reloads
                  if (ch_dac[7]) ch_running = 1'b1;
                  if (ch_len_cnt == '0) ch_len_cnt = LENGTH_SPAN;
                  ch_period = {r.wdata[2:0], ch_plow};
                  ch_timer  = reload_ticks();
                  ch_pos    = '0;
               end
            end else if (r.addr[15:4] == ADDR_WAVE_PAGE) begin
               ch_wave[r.addr[3:0]] = r.wdata;
            end
         end
         REQ_PERIOD: begin
            // idle timer (never triggered) stays at zero
            if (ch_timer != '0) begin
               ch_timer = ch_timer - 1'b1;
               if (ch_timer == '0) begin
                  ch_timer = reload_ticks();
                  ch_pos   = ch_pos + 1'b1;
               end
            end
         end
         default: begin
            if (ch_ctrl[6] && ch_len_cnt != '0) begin
               ch_len_cnt = ch_len_cnt - 1'b1;
               if (ch_len_cnt == '0) ch_running = 1'b0;
            end
         end
      endcase
      wave_byte = ch_wave[ch_pos[4:1]];
      nib = ch_pos[0] ? wave_byte[3:0] : wave_byte[7:4];
      if (!ch_running || !ch_dac[7] || ch_vol[6:5] == 2'd0) res.sample = '0;
      else res.sample = nib >> (ch_vol[6:5] - 2'd1);
      res.channel_on = ch_running;
      return res;
   endfunction

   task automatic flag_error(string msg);
      err_count++;
      if (err_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic push_req(req_kind_type kind, logic [15:0] addr, byte_type wdata);
      req_backlog.push_back(wave_req_type'{kind, addr, wdata});
      items_queued++;
   endtask

   // channel registers, wave RAM and their unmapped neighbors
   function automatic logic [15:0] mapped_addr();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return ADDR_DAC + 16'(pick);
      if (pick < 9) return {ADDR_WAVE_PAGE, 4'($urandom_range(15))};
      case ($urandom_range(3))
         0: return ADDR_DAC - 16'd1;
         1: return ADDR_CTRL + 16'd1;
         2: return {ADDR_WAVE_PAGE, 4'h0} - 16'd1;
         default: return {ADDR_WAVE_PAGE, 4'hF} + 16'd1;
      endcase
   endfunction

   // one note: set up the channel, trigger it, then let it play with ticks
   task automatic add_note();
      int          n_run;
      int          pick;
      logic [2:0]  per_hi;
      byte_type    per_lo;
      push_req(REQ_WRITE, ADDR_DAC, ($urandom_range(9) == 0) ?
               byte_type'($urandom_range(127)) : (byte_type'($urandom) | 8'h80));
      push_req(REQ_WRITE, ADDR_VOLUME, byte_type'($urandom));
      repeat ($urandom_range(4))
         push_req(REQ_WRITE, {ADDR_WAVE_PAGE, 4'($urandom_range(15))}, byte_type'($urandom));
      // mostly short lengths so the length counter runs out
      push_req(REQ_WRITE, ADDR_LENGTH, ($urandom_range(3) == 0) ?
               byte_type'($urandom) : byte_type'(255 - $urandom_range(12)));
      // mostly short periods so the position actually moves
      if ($urandom_range(7) == 0) begin
         per_lo = byte_type'($urandom);
         per_hi = 3'($urandom);
      end else begin
         per_lo = 8'hF0 | byte_type'($urandom_range(15));
         per_hi = 3'b111;
      end
      push_req(REQ_WRITE, ADDR_PLOW, per_lo);
      push_req(REQ_WRITE, ADDR_CTRL, {1'b1, 1'($urandom_range(4) != 0), 3'($urandom), per_hi});
      n_run = ($urandom_range(4) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 8);
      repeat (n_run) begin
         pick = $urandom_range(99);
         if (pick < 55) push_req(REQ_PERIOD, 16'($urandom), byte_type'($urandom));
         else if (pick < 80) push_req(REQ_LENGTH, 16'($urandom), byte_type'($urandom));
         else if (pick < 90) push_req(REQ_READ, mapped_addr(), byte_type'($urandom));
         else if (pick < 95)
            push_req(REQ_WRITE, {ADDR_WAVE_PAGE, 4'($urandom_range(15))}, byte_type'($urandom));
         else if (pick < 97) push_req(REQ_WRITE, ADDR_VOLUME, byte_type'($urandom));
         else if (pick < 99) push_req(REQ_WRITE, ADDR_CTRL, byte_type'($urandom));
         else push_req(REQ_WRITE, ADDR_DAC, byte_type'($urandom));
      end
   endtask

   task automatic add_random(int n);
      int target;
      target = items_queued + n;
      while (items_queued < target) begin
         if ($urandom_range(9) == 0)
            push_req(req_kind_type'($urandom_range(3)),
                     ($urandom_range(1) == 0) ? 16'($urandom) : mapped_addr(),
                     byte_type'($urandom));
         else
            add_note();
      end
   endtask

   // sender stays quiet until every predicted response has come back
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || rsp_expected.size() != 0)
         @(negedge clock);
   endtask

   // stimulus: directed part, then three random phases with different idling
   initial begin
      @(negedge clock);
      push_req(REQ_READ,   ADDR_DAC, 8'h00);           // reset value read-back
      push_req(REQ_PERIOD, 16'h0000, 8'h00);           // timer idle at zero
      push_req(REQ_LENGTH, 16'h0000, 8'h00);           // length count at zero
      push_req(REQ_WRITE,  16'h0000, 8'hFF);           // unmapped write ignored
      push_req(REQ_READ,   16'hFFFF, 8'hFF);           // unmapped read
      push_req(REQ_WRITE,  {ADDR_WAVE_PAGE, 4'h0}, 8'hA5);
      push_req(REQ_WRITE,  {ADDR_WAVE_PAGE, 4'hF}, 8'h5A);
      push_req(REQ_READ,   {ADDR_WAVE_PAGE, 4'hF}, 8'h00);
      push_req(REQ_WRITE,  ADDR_CTRL, 8'h87);          // trigger, DAC off, count zero
      push_req(REQ_WRITE,  ADDR_DAC, 8'h80);
      push_req(REQ_WRITE,  ADDR_VOLUME, 8'h20);        // full volume
      push_req(REQ_WRITE,  ADDR_PLOW, 8'hFF);
      push_req(REQ_WRITE,  ADDR_LENGTH, 8'hFF);        // one length tick left
      push_req(REQ_WRITE,  ADDR_CTRL, 8'hC7);          // trigger, length on, shortest period
      push_req(REQ_READ,   {ADDR_WAVE_PAGE, 4'h0}, 8'h00);   // blocked while running
      push_req(REQ_WRITE,  {ADDR_WAVE_PAGE, 4'h1}, 8'h3C);   // stored while running
      push_req(REQ_PERIOD, 16'h0000, 8'h00);
      push_req(REQ_PERIOD, 16'h0000, 8'h00);           // position steps to low nibble
      push_req(REQ_WRITE,  ADDR_VOLUME, 8'h40);        // half
      push_req(REQ_WRITE,  ADDR_VOLUME, 8'h60);        // quarter
      push_req(REQ_WRITE,  ADDR_VOLUME, 8'h00);        // mute
      push_req(REQ_LENGTH, 16'h0000, 8'h00);           // expires, channel off
      push_req(REQ_LENGTH, 16'h0000, 8'h00);           // count already zero
      push_req(REQ_WRITE,  ADDR_CTRL, 8'hC7);          // retrigger with zero count
      push_req(REQ_WRITE,  ADDR_DAC, 8'h00);           // DAC off stops the channel
      push_req(REQ_READ,   ADDR_CTRL, 8'h00);

      add_random(PHASE_ITEMS);
      wait_drained();
      send_idle_pct <= 47;
      rsp_idle_pct  <= 30;
      add_random(PHASE_ITEMS);
      wait_drained();
      send_idle_pct <= 0;
      rsp_idle_pct  <= 0;
      add_random(PHASE_ITEMS);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // long receiver hold-off while the driver keeps offering requests
   initial begin
      while (req_accepted < HOLD_AFTER) @(negedge clock);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // driver: predict on acceptance, then offer the next request or idle
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         ch_dac     = '0;
         ch_vol     = '0;
         ch_plow    = '0;
         ch_ctrl    = '0;
         ch_running = 1'b0;
         ch_period  = '0;
         ch_timer   = '0;
         ch_pos     = '0;
         ch_len_cnt = '0;
         foreach (ch_wave[i]) ch_wave[i] = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_expected.push_back(predict_channel(req_on_bus));
            req_accepted++;
         end
         // valid holds while the transaction is pending; one assignment per edge
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_on_bus = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= req_on_bus.kind;
               req_tdata  <= {req_on_bus.wdata, req_on_bus.addr};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each response transaction, then choose ready for the next edge
   always @(posedge clock) begin : rsp_monitor
      wave_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_expected.size() == 0) begin
               flag_error($sformatf("response %h with nothing expected", rsp_tdata));
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_tdata[7:0] !== want.read_data || rsp_tdata[11:8] !== want.sample ||
                   rsp_tdata[12] !== want.channel_on)
                  flag_error($sformatf(
                     "read_data %h/%h sample %h/%h channel_on %b/%b (expected/actual)",
                     want.read_data, rsp_tdata[7:0], want.sample, rsp_tdata[11:8],
                     want.channel_on, rsp_tdata[12]));
            end
         end
         rsp_tready <= !hold_active && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog: ends the run if no transaction moves for too long
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
